/* hdl/rrgco_pkg.sv */
// Shared types, constants and codes for the rotated risk grid cost overlay.
package rrgco_pkg;

    localparam int MAX_CELLS = 65536;
    localparam int ADDR_W    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int MIN_RISK  = 1;

    localparam int RISK_FULL    = 100;
    localparam int COST_CAP     = 252;
    localparam int COST_UNKNOWN = 255;
    localparam int ROUND_HALF   = 50;

    // floor(x / 100) == (x * 5243) >> 19 for x below 43690
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_COS_YAW,
        CFG_SIN_YAW,
        CFG_CELLS_PER_METER,
        CFG_GRID_WIDTH,
        CFG_GRID_HEIGHT,
        CFG_PEAK_COST
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OUT_WRITTEN,
        OUT_NO_MAP,
        OUT_OUTSIDE,
        OUT_FREE,
        OUT_COST_UNKNOWN
    } outcome_t;

    typedef struct packed {
        logic               kind;
        logic [15:0]        load_index;
        logic signed [7:0]  risk_level;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic [7:0]         cost_now;
    } item_t;

    typedef struct packed {
        logic [7:0] new_cost;
        logic       cell_written;
        logic [2:0] outcome;
    } result_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [17:0] cos_yaw;
        logic signed [17:0] sin_yaw;
        logic [24:0]        cells_per_meter;
        logic [12:0]        grid_width;
        logic [12:0]        grid_height;
        logic [7:0]         peak_cost;
    } cfg_t;

    // Located transaction handed from the geometry pipeline to the store stage
    typedef struct packed {
        logic              kind;
        logic [15:0]       load_index;
        logic signed [7:0] risk_level;
        logic [7:0]        cost_now;
        logic              outside;
        logic [ADDR_W-1:0] cell_idx;
    } loc_t;

endpackage

/* hdl/rrgco_locate.sv */
// Six-stage geometry pipeline: origin offset, rotation, scaling to cells, row-major index.
module rrgco_locate
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 up_ready,
    input  rrgco_pkg::item_t     item,
    input  rrgco_pkg::cfg_t      cfg,
    output logic                 loc_valid,
    input  logic                 down_ready,
    output rrgco_pkg::loc_t      loc
);

    typedef struct packed {
        logic              kind;
        logic [15:0]       load_index;
        logic signed [7:0] risk_level;
        logic [7:0]        cost_now;
    } side_t;

    logic [6:1] vld_reg;
    logic [6:1] ld;
    side_t      side_reg [6:1];

    // stage 1: offset from origin
    logic signed [32:0] dx_next, dy_next, dx_reg, dy_reg;
    // stage 2: rotation products
    logic signed [50:0] pxc_next, pxs_next, pyc_next, pys_next;
    logic signed [50:0] pxc_reg, pxs_reg, pyc_reg, pys_reg;
    // stage 3: local coordinates, floored to Q19.16
    logic signed [51:0] lx_next, ly_next;
    logic [34:0]        qx_reg, qy_reg;
    logic               out3_reg;
    // stage 4: partial products of the scaling
    logic [42:0]        ppx_lo_next, ppy_lo_next, ppx_lo_reg, ppy_lo_reg;
    logic [41:0]        ppx_hi_next, ppy_hi_next, ppx_hi_reg, ppy_hi_reg;
    logic               out4_reg;
    // stage 5: cell coordinates
    logic [60:0]        fullx_next, fully_next;
    logic [28:0]        gx_full, gy_full;
    logic               out5_next;
    logic [12:0]        gx_reg, gy_reg;
    logic               out5_reg;
    // stage 6: row-major index
    logic [25:0]        row_next;
    logic [26:0]        idx_next;
    logic [rrgco_pkg::ADDR_W-1:0] idx_reg;
    logic               out6_reg;

    always_comb
    begin
        ld[6] = !vld_reg[6] || down_ready;
        for (int i = 5; i >= 1; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
    end

    assign up_ready = ld[1];

    always_comb
    begin
        dx_next = {item.world_x[31], item.world_x} - {cfg.origin_x[31], cfg.origin_x};
        dy_next = {item.world_y[31], item.world_y} - {cfg.origin_y[31], cfg.origin_y};

        pxc_next = $signed(cfg.cos_yaw) * dx_reg;
        pxs_next = $signed(cfg.sin_yaw) * dy_reg;
        pyc_next = $signed(cfg.cos_yaw) * dy_reg;
        pys_next = $signed(cfg.sin_yaw) * dx_reg;

        lx_next = {pxc_reg[50], pxc_reg} + {pxs_reg[50], pxs_reg};
        ly_next = {pyc_reg[50], pyc_reg} - {pys_reg[50], pys_reg};

        ppx_lo_next = qx_reg[17:0]  * cfg.cells_per_meter;
        ppx_hi_next = qx_reg[34:18] * cfg.cells_per_meter;
        ppy_lo_next = qy_reg[17:0]  * cfg.cells_per_meter;
        ppy_hi_next = qy_reg[34:18] * cfg.cells_per_meter;

        fullx_next = 61'({ppx_hi_reg, 18'd0}) + 61'(ppx_lo_reg);
        fully_next = 61'({ppy_hi_reg, 18'd0}) + 61'(ppy_lo_reg);
        gx_full    = fullx_next[60:32];
        gy_full    = fully_next[60:32];
        out5_next  = out4_reg
                     || (|gx_full[28:13]) || (gx_full[12:0] >= cfg.grid_width)
                     || (|gy_full[28:13]) || (gy_full[12:0] >= cfg.grid_height);

        row_next = gy_reg * cfg.grid_width;
        idx_next = 27'(row_next) + 27'(gx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[1])
            begin
                vld_reg[1] <= item_valid;
            end
            for (int i = 2; i <= 6; i++)
            begin
                if (ld[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            side_reg[1] <= '{kind: item.kind, load_index: item.load_index,
                             risk_level: item.risk_level, cost_now: item.cost_now};
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (ld[2])
        begin
            side_reg[2] <= side_reg[1];
            pxc_reg <= pxc_next;
            pxs_reg <= pxs_next;
            pyc_reg <= pyc_next;
            pys_reg <= pys_next;
        end
        if (ld[3])
        begin
            side_reg[3] <= side_reg[2];
            qx_reg   <= lx_next[50:16];
            qy_reg   <= ly_next[50:16];
            out3_reg <= lx_next[51] || ly_next[51];
        end
        if (ld[4])
        begin
            side_reg[4] <= side_reg[3];
            ppx_lo_reg <= ppx_lo_next;
            ppx_hi_reg <= ppx_hi_next;
            ppy_lo_reg <= ppy_lo_next;
            ppy_hi_reg <= ppy_hi_next;
            out4_reg   <= out3_reg;
        end
        if (ld[5])
        begin
            side_reg[5] <= side_reg[4];
            gx_reg   <= gx_full[12:0];
            gy_reg   <= gy_full[12:0];
            out5_reg <= out5_next;
        end
        if (ld[6])
        begin
            side_reg[6] <= side_reg[5];
            idx_reg  <= rrgco_pkg::ADDR_W'(idx_next);
            out6_reg <= out5_reg || (idx_next >= 27'(rrgco_pkg::MAX_CELLS));
        end
    end

    assign loc_valid      = vld_reg[6];
    assign loc.kind       = side_reg[6].kind;
    assign loc.load_index = side_reg[6].load_index;
    assign loc.risk_level = side_reg[6].risk_level;
    assign loc.cost_now   = side_reg[6].cost_now;
    assign loc.outside    = out6_reg;
    assign loc.cell_idx   = idx_reg;

endmodule

/* hdl/rotated_risk_grid_cost_overlay.sv */
// Top level: configuration, geometry pipeline, risk store and cost stages.
//
//  channel   direction  handshake                     payload
//  item      in         item_valid / item_stall       rrgco_pkg::item_t
//  result    out        result_valid / result_stall   rrgco_pkg::result_t
//  cfg       in         cfg_we                        cfg_index, cfg_data
//
// One transaction per cycle sustained while no result stall holds the stages.
// Six geometry stages, one store access stage, two cost stages; each holds only while
// the stage after it is full and held, so bubbles close up under a result stall.
// Load transactions write the store in order with process reads and give no result.
// Reset clears valid bits and loaded flag, sets default config; the store is kept.
module rotated_risk_grid_cost_overlay
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  rrgco_pkg::item_t    item,
    output logic                result_valid,
    input  logic                result_stall,
    output rrgco_pkg::result_t  result,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    rrgco_pkg::cfg_t cfg_reg;

    logic            up_ready;
    logic            loc_valid;
    rrgco_pkg::loc_t loc;

    logic ld7, ld8, ld9;
    logic take6, mem_we, mem_re, load_in_range;
    logic [rrgco_pkg::ADDR_W-1:0] mem_addr;

    logic [7:0] risk_mem [rrgco_pkg::MAX_CELLS];
    logic [7:0] rd_reg;
    logic       map_loaded_reg;

    logic                 v7_reg, v8_reg, v9_reg;
    rrgco_pkg::outcome_t  pre7_next, pre7_reg, pre8_next, pre8_reg;
    logic [7:0]           cur7_reg, cur8_reg;
    logic                 free8;
    logic [6:0]           risk_v;
    logic [14:0]          prod8_next, prod8_reg;
    logic [14:0]          sum9;
    logic [27:0]          qprod9;
    logic [8:0]           rc9;
    logic [7:0]           rc8;
    rrgco_pkg::result_t   res_next, res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x        <= '0;
            cfg_reg.origin_y        <= '0;
            cfg_reg.cos_yaw         <= 18'sd65536;
            cfg_reg.sin_yaw         <= '0;
            cfg_reg.cells_per_meter <= 25'd1310720;
            cfg_reg.grid_width      <= 13'd256;
            cfg_reg.grid_height     <= 13'd256;
            cfg_reg.peak_cost       <= 8'd200;
        end
        else if (cfg_we)
        begin
            unique case (rrgco_pkg::cfg_idx_t'(cfg_index))
                rrgco_pkg::CFG_ORIGIN_X:        cfg_reg.origin_x        <= cfg_data;
                rrgco_pkg::CFG_ORIGIN_Y:        cfg_reg.origin_y        <= cfg_data;
                rrgco_pkg::CFG_COS_YAW:         cfg_reg.cos_yaw         <= cfg_data[17:0];
                rrgco_pkg::CFG_SIN_YAW:         cfg_reg.sin_yaw         <= cfg_data[17:0];
                rrgco_pkg::CFG_CELLS_PER_METER: cfg_reg.cells_per_meter <= cfg_data[24:0];
                rrgco_pkg::CFG_GRID_WIDTH:      cfg_reg.grid_width      <= cfg_data[12:0];
                rrgco_pkg::CFG_GRID_HEIGHT:     cfg_reg.grid_height     <= cfg_data[12:0];
                rrgco_pkg::CFG_PEAK_COST:       cfg_reg.peak_cost       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    rrgco_locate u_locate
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .up_ready   (up_ready),
        .item       (item),
        .cfg        (cfg_reg),
        .loc_valid  (loc_valid),
        .down_ready (ld7),
        .loc        (loc)
    );

    assign item_stall = !up_ready;

    assign ld9 = !v9_reg || !result_stall;
    assign ld8 = !v8_reg || ld9;
    assign ld7 = !v7_reg || ld8;

    // store access: loads write, process transactions read, both in arrival order
    assign take6         = loc_valid && ld7;
    assign load_in_range = 25'(loc.load_index) < 25'(rrgco_pkg::MAX_CELLS);
    assign mem_we        = take6 && !loc.kind && load_in_range;
    assign mem_re        = take6 && loc.kind;
    assign mem_addr      = loc.kind ? loc.cell_idx : rrgco_pkg::ADDR_W'(loc.load_index);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            risk_mem[mem_addr] <= loc.risk_level;
        end
        if (mem_re)
        begin
            rd_reg <= risk_mem[mem_addr];
        end
    end

    always_comb
    begin
        if (!map_loaded_reg || (cfg_reg.cells_per_meter == '0))
        begin
            pre7_next = rrgco_pkg::OUT_NO_MAP;
        end
        else if (loc.outside)
        begin
            pre7_next = rrgco_pkg::OUT_OUTSIDE;
        end
        else
        begin
            pre7_next = rrgco_pkg::OUT_WRITTEN;
        end

        free8 = $signed(rd_reg) < rrgco_pkg::MIN_RISK;
        if (free8)
        begin
            risk_v = '0;
        end
        else if ($signed(rd_reg) > rrgco_pkg::RISK_FULL)
        begin
            risk_v = 7'(rrgco_pkg::RISK_FULL);
        end
        else
        begin
            risk_v = rd_reg[6:0];
        end
        prod8_next = risk_v * cfg_reg.peak_cost;
        pre8_next  = pre7_reg;

        sum9   = prod8_reg + 15'(rrgco_pkg::ROUND_HALF);
        qprod9 = sum9 * 13'(rrgco_pkg::DIV100_MUL);
        rc9    = 9'(qprod9 >> rrgco_pkg::DIV100_SHIFT);
        rc8    = (rc9 > 9'(rrgco_pkg::COST_CAP)) ? 8'(rrgco_pkg::COST_CAP) : rc9[7:0];

        res_next.new_cost = cur8_reg;
        if (pre8_reg != rrgco_pkg::OUT_WRITTEN)
        begin
            res_next.outcome = pre8_reg;
        end
        else if (rc8 == '0)
        begin
            res_next.outcome = rrgco_pkg::OUT_FREE;
        end
        else if (cur8_reg == 8'(rrgco_pkg::COST_UNKNOWN))
        begin
            res_next.outcome = rrgco_pkg::OUT_COST_UNKNOWN;
        end
        else
        begin
            res_next.outcome  = rrgco_pkg::OUT_WRITTEN;
            res_next.new_cost = (rc8 > cur8_reg) ? rc8 : cur8_reg;
        end
        res_next.cell_written = (res_next.outcome == rrgco_pkg::OUT_WRITTEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_loaded_reg <= 1'b0;
            v7_reg         <= 1'b0;
            v8_reg         <= 1'b0;
            v9_reg         <= 1'b0;
        end
        else
        begin
            if (take6 && !loc.kind)
            begin
                map_loaded_reg <= 1'b1;
            end
            if (ld7)
            begin
                v7_reg <= loc_valid && loc.kind;
            end
            if (ld8)
            begin
                v8_reg <= v7_reg;
            end
            if (ld9)
            begin
                v9_reg <= v8_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld7)
        begin
            pre7_reg <= pre7_next;
            cur7_reg <= loc.cost_now;
        end
        if (ld8)
        begin
            pre8_reg  <= pre8_next;
            cur8_reg  <= cur7_reg;
            prod8_reg <= prod8_next;
        end
        if (ld9)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = v9_reg;
    assign result       = res_reg;

`ifndef NO_ASSERTIONS
    a_loaded_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        map_loaded_reg |=> map_loaded_reg)
        else $error("loaded flag dropped");

    a_written_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.cell_written == (result.outcome == rrgco_pkg::OUT_WRITTEN)))
        else $error("written flag disagrees with outcome");

    a_written_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.cell_written) |-> (result.new_cost != 8'hFF))
        else $error("unknown cost written");

    a_unknown_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.outcome == rrgco_pkg::OUT_COST_UNKNOWN))
        |-> (result.new_cost == 8'hFF))
        else $error("unknown cost not kept");

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store read and written in one cycle");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the risk grid cost overlay: queued stimulus, cost predictor.
module tb_top;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PROCESS = 1'b1;
    localparam int   QUIET_LIMIT  = 5000;
    localparam int   SETTLE_CYCLES = 12;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    rrgco_pkg::item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    rrgco_pkg::result_t result;
    logic    cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    rrgco_pkg::cfg_t cfg_now = '{32'sd0, 32'sd0, 18'sd65536, 18'sd0, 25'd1310720, 13'd256,
                                 13'd256, 8'd200};

    rrgco_pkg::item_t   pending[$];
    rrgco_pkg::result_t cost_due[$];
    rrgco_pkg::result_t want;

    logic signed [7:0] risk_mirror [rrgco_pkg::MAX_CELLS];
    bit      map_ready = 1'b0;
    bit      gen_seeded [rrgco_pkg::MAX_CELLS];
    bit      gen_loaded = 1'b0;

    int burst_left = 1;
    int gap_left = 0;
    int ticks = 0;
    int quiet = 0;
    int faults = 0;
    int taken = 0;
    int loads_taken = 0;
    int checked = 0;
    int phases = 0;

    rotated_risk_grid_cost_overlay DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // OUT_WRITTEN here means the cell lies inside the grid and idx is valid
    function automatic rrgco_pkg::outcome_t locate_cell(input rrgco_pkg::item_t it,
                                                        input rrgco_pkg::cfg_t c,
                                                        input bit loaded,
                                                        output int unsigned idx);
        longint dx;
        longint dy;
        longint lx;
        longint ly;
        longint unsigned gx;
        longint unsigned gy;
        longint unsigned lin;
        idx = 0;
        if (!loaded || c.cells_per_meter == 0)
            return rrgco_pkg::OUT_NO_MAP;
        dx = longint'($signed(it.world_x)) - longint'($signed(c.origin_x));
        dy = longint'($signed(it.world_y)) - longint'($signed(c.origin_y));
        lx = longint'($signed(c.cos_yaw)) * dx + longint'($signed(c.sin_yaw)) * dy;
        ly = longint'($signed(c.cos_yaw)) * dy - longint'($signed(c.sin_yaw)) * dx;
        if (lx < 0 || ly < 0)
            return rrgco_pkg::OUT_OUTSIDE;
        gx = ((lx >> 16) * c.cells_per_meter) >> 32;
        gy = ((ly >> 16) * c.cells_per_meter) >> 32;
        if (gx >= c.grid_width || gy >= c.grid_height)
            return rrgco_pkg::OUT_OUTSIDE;
        lin = gy * c.grid_width + gx;
        if (lin >= rrgco_pkg::MAX_CELLS)
            return rrgco_pkg::OUT_OUTSIDE;
        idx = lin[31:0];
        return rrgco_pkg::OUT_WRITTEN;
    endfunction

    function automatic int cost_of_risk(input logic signed [7:0] risk, input logic [7:0] top);
        int v;
        int c;
        v = risk;
        if (v < rrgco_pkg::MIN_RISK)
            return 0;
        if (v > rrgco_pkg::RISK_FULL)
            v = rrgco_pkg::RISK_FULL;
        c = (v * int'(top) + rrgco_pkg::ROUND_HALF) / rrgco_pkg::RISK_FULL;
        return (c > rrgco_pkg::COST_CAP) ? rrgco_pkg::COST_CAP : c;
    endfunction

    function automatic rrgco_pkg::result_t overlay_result(input rrgco_pkg::item_t it);
        rrgco_pkg::result_t r;
        rrgco_pkg::outcome_t o;
        int unsigned idx;
        int cost;
        o = locate_cell(it, cfg_now, map_ready, idx);
        r.new_cost = it.cost_now;
        if (o == rrgco_pkg::OUT_WRITTEN)
        begin
            cost = cost_of_risk(risk_mirror[idx], cfg_now.peak_cost);
            if (cost == 0)
                o = rrgco_pkg::OUT_FREE;
            else if (it.cost_now == rrgco_pkg::COST_UNKNOWN)
                o = rrgco_pkg::OUT_COST_UNKNOWN;
            else if (cost > it.cost_now)
                r.new_cost = 8'(cost);
        end
        r.outcome = o;
        r.cell_written = (o == rrgco_pkg::OUT_WRITTEN);
        return r;
    endfunction

    function automatic rrgco_pkg::item_t noise_item();
        rrgco_pkg::item_t it;
        it.kind = 1'($urandom);
        it.load_index = 16'($urandom);
        it.risk_level = 8'($urandom);
        it.world_x = $urandom;
        it.world_y = $urandom;
        it.cost_now = 8'($urandom);
        return it;
    endfunction

    function automatic logic signed [7:0] pick_risk();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, rrgco_pkg::RISK_FULL));
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_cost();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'(rrgco_pkg::COST_UNKNOWN);
        if (r == 1)
            return 8'd0;
        return 8'($urandom_range(0, rrgco_pkg::COST_UNKNOWN - 1));
    endfunction

    // World position whose local offset lands inside cell (gx, gy)
    function automatic rrgco_pkg::item_t probe_item(input int gx, input int gy,
                                                    input logic [7:0] cur);
        rrgco_pkg::item_t it;
        longint cpm;
        longint lx;
        longint ly;
        longint c;
        longint s;
        longint dx;
        longint dy;
        it = noise_item();
        it.kind = KIND_PROCESS;
        it.cost_now = cur;
        cpm = longint'(cfg_now.cells_per_meter);
        lx = ((longint'(gx) << 32) + longint'($urandom_range(32'h6000_0000, 32'hA000_0000))) / cpm;
        ly = ((longint'(gy) << 32) + longint'($urandom_range(32'h6000_0000, 32'hA000_0000))) / cpm;
        c = longint'($signed(cfg_now.cos_yaw));
        s = longint'($signed(cfg_now.sin_yaw));
        dx = (c * lx - s * ly) >>> 16;
        dy = (s * lx + c * ly) >>> 16;
        it.world_x = 32'(longint'($signed(cfg_now.origin_x)) + dx);
        it.world_y = 32'(longint'($signed(cfg_now.origin_y)) + dy);
        return it;
    endfunction

    // Never let a probe read a store entry that has not been loaded
    task automatic queue_item(input rrgco_pkg::item_t it);
        rrgco_pkg::outcome_t o;
        int unsigned idx;
        rrgco_pkg::item_t ld;
        if (it.kind == KIND_PROCESS)
        begin
            o = locate_cell(it, cfg_now, gen_loaded, idx);
            if (o == rrgco_pkg::OUT_WRITTEN && !gen_seeded[idx])
            begin
                ld = noise_item();
                ld.kind = KIND_LOAD;
                ld.load_index = idx[15:0];
                ld.risk_level = pick_risk();
                gen_seeded[idx] = 1'b1;
                pending.push_back(ld);
            end
        end
        else
        begin
            gen_seeded[it.load_index] = 1'b1;
            gen_loaded = 1'b1;
        end
        pending.push_back(it);
    endtask

    task automatic push_load(input int idx, input logic signed [7:0] risk);
        rrgco_pkg::item_t ld;
        ld = noise_item();
        ld.kind = KIND_LOAD;
        ld.load_index = 16'(idx);
        ld.risk_level = risk;
        queue_item(ld);
    endtask

    task automatic push_probe(input int gx, input int gy, input logic [7:0] cur);
        queue_item(probe_item(gx, gy, cur));
    endtask

    task automatic push_world(input logic signed [31:0] wx, input logic signed [31:0] wy);
        rrgco_pkg::item_t it;
        it = noise_item();
        it.kind = KIND_PROCESS;
        it.world_x = wx;
        it.world_y = wy;
        queue_item(it);
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pending.size() != 0 || item_valid || cost_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input rrgco_pkg::cfg_idx_t r, input logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
    endtask

    task automatic set_registers(input rrgco_pkg::cfg_t c);
        write_reg(rrgco_pkg::CFG_ORIGIN_X, c.origin_x);
        write_reg(rrgco_pkg::CFG_ORIGIN_Y, c.origin_y);
        write_reg(rrgco_pkg::CFG_COS_YAW, 32'($signed(c.cos_yaw)));
        write_reg(rrgco_pkg::CFG_SIN_YAW, 32'($signed(c.sin_yaw)));
        write_reg(rrgco_pkg::CFG_CELLS_PER_METER, 32'(c.cells_per_meter));
        write_reg(rrgco_pkg::CFG_GRID_WIDTH, 32'(c.grid_width));
        write_reg(rrgco_pkg::CFG_GRID_HEIGHT, 32'(c.grid_height));
        write_reg(rrgco_pkg::CFG_PEAK_COST, 32'(c.peak_cost));
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_now = c;
        phases++;
    endtask

    task automatic run_phase(input rrgco_pkg::cfg_t c, input int n);
        rrgco_pkg::item_t it;
        int roll;
        int w;
        int h;
        int rows;
        int gx;
        int gy;
        bit aimable;
        settle();
        set_registers(c);
        w = cfg_now.grid_width;
        h = cfg_now.grid_height;
        aimable = (cfg_now.cells_per_meter != 0) && (w != 0) && (h != 0);
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            it = noise_item();
            if (roll < 10)
            begin
                it.kind = KIND_LOAD;
                it.risk_level = pick_risk();
            end
            else if (roll < 22 || !aimable)
                it.kind = KIND_PROCESS;
            else
            begin
                rows = h;
                if (w * h > rrgco_pkg::MAX_CELLS && $urandom_range(0, 3) != 0)
                    rows = rrgco_pkg::MAX_CELLS / w;
                gx = $urandom_range(0, w - 1);
                gy = $urandom_range(0, rows - 1);
                if ($urandom_range(0, 9) == 0)
                begin
                    if ($urandom_range(0, 1) == 1)
                        gx = w;
                    else
                        gy = h;
                end
                it = probe_item(gx, gy, pick_cost());
                if (gy * w + gx < rrgco_pkg::MAX_CELLS && $urandom_range(0, 4) == 0)
                    push_load(gy * w + gx, pick_risk());
            end
            queue_item(it);
        end
    endtask

    task automatic flag_error(input string msg);
        faults++;
        if (faults <= 10)
            $display("mismatch: %s", msg);
    endtask

    // Driver: one transaction per handshake, bursts separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                taken++;
                if (item.kind == KIND_LOAD)
                begin
                    risk_mirror[item.load_index] = item.risk_level;
                    map_ready = 1'b1;
                    loads_taken++;
                end
                else
                    cost_due.push_back(overlay_result(item));
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0 || pending.size() == 0)
                begin
                    item_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    item_valid <= 1'b1;
                    item <= pending.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest prediction, stalls on its own pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            ticks++;
            if (result_valid && !result_stall)
            begin
                checked++;
                if (cost_due.size() == 0)
                    flag_error($sformatf("unexpected result cost %0d written %0d outcome %0d",
                                         result.new_cost, result.cell_written, result.outcome));
                else
                begin
                    want = cost_due.pop_front();
                    if (result.new_cost !== want.new_cost
                        || result.cell_written !== want.cell_written
                        || result.outcome !== want.outcome)
                        flag_error($sformatf(
                            "expected cost %0d written %0d outcome %0d, got %0d %0d %0d",
                            want.new_cost, want.cell_written, want.outcome,
                            result.new_cost, result.cell_written, result.outcome));
                end
            end
            case ((ticks / 256) % 4)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 9) < 6);
                default: result_stall <= ((ticks % 5) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: nothing loaded yet, then the store corners and risk mapping cases
        push_probe(0, 0, 8'd0);
        push_probe(3, 3, 8'(rrgco_pkg::COST_UNKNOWN));
        push_load(0, 8'sd100);
        push_load(1, 8'sd50);
        push_load(2, -8'sd1);
        push_load(3, 8'sd0);
        push_load(4, 8'sd127);
        push_load(rrgco_pkg::MAX_CELLS - 1, 8'sd1);
        push_load(256, -8'sd128);
        push_probe(0, 0, 8'd0);
        push_probe(0, 0, 8'(rrgco_pkg::COST_UNKNOWN));
        push_probe(1, 0, 8'd250);
        push_probe(1, 0, 8'd10);
        push_probe(2, 0, 8'd5);
        push_probe(3, 0, 8'd5);
        push_probe(4, 0, 8'd7);
        push_probe(255, 255, 8'd0);
        push_probe(0, 1, 8'd100);
        push_probe(256, 0, 8'd1);
        push_probe(0, 256, 8'd1);
        push_world(-32'sd1, 32'sd0);
        push_world(32'sh7FFF_FFFF, 32'sh8000_0000);
        push_world(32'sh7FFF_FFFF, 32'sd0);

        run_phase('{32'sd0, 32'sd0, 18'sd65536, 18'sd0, 25'd262144, 13'd64, 13'd64, 8'd252}, 170);
        run_phase('{-32'sd327680, 32'sd196608, 18'sd0, 18'sd65536, 25'd1310720, 13'd256,
                    13'd256, 8'd1}, 140);
        run_phase('{32'sh8000_0000, 32'sh7FFF_FFFF, 18'sd0, -18'sd65536, 25'd16777216,
                    13'd4096, 13'd4096, 8'd255}, 140);
        run_phase('{32'sd819200, -32'sd475136, 18'sd46341, 18'sd46341, 25'd131072, 13'd100,
                    13'd300, 8'd100}, 140);
        run_phase('{32'sh8000_0000, 32'sh8000_0000, 18'sd65536, 18'sd0, 25'd1, 13'd1, 13'd1,
                    8'd37}, 100);
        run_phase('{32'sd0, 32'sd0, -18'sd65536, 18'sd65536, 25'd0, 13'd256, 13'd256,
                    8'd200}, 30);
        run_phase('{32'sd0, 32'sd0, 18'sd65536, 18'sd0, 25'd1310720, 13'd0, 13'd0, 8'd200}, 30);
        run_phase('{32'sd1000000, -32'sd2000000, -18'sd30000, 18'sd59000, 25'd40000, 13'd4096,
                    13'd16, 8'd150}, 110);
        settle();

        $display("summary: %0d transactions sent (%0d risk loads), %0d costs checked",
                 taken, loads_taken, checked);
        $display("summary: %0d register settings after the reset ones, %0d mismatches",
                 phases, faults);
        if (faults == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
hdl/rrgco_pkg.sv
hdl/rrgco_locate.sv
hdl/rotated_risk_grid_cost_overlay.sv
tb/tb_top.sv
